### hdl/bfp_pkg.sv
// ----------------------------------------------------------------------------
// bfp_pkg: shared types and constants for the bit-field packer/unpacker
// Register indexes, state widths and the value mask helper used by the
// datapath and the shared shift unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfp_pkg;

    // Widths of the message state
    localparam int BUF_W     = 15;
    localparam int HELD_W    = 4;
    localparam int CNT_W     = 32;
    localparam int DATA_W    = 8;
    localparam int SHAMT_W   = 4;
    localparam int EMIT_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

    // Mode codes
    localparam logic MODE_PACK   = 1'b0;
    localparam logic MODE_UNPACK = 1'b1;

    // Reset values and fixed amounts
    localparam logic [HELD_W-1:0] BYTE_BITS   = 4'd8;
    localparam logic [HELD_W-1:0] RESET_WIDTH = 4'd8;
    localparam logic [CNT_W-1:0]  RESET_COUNT = 32'd1;
    localparam logic [EMIT_W-1:0] EMIT_MAX    = 3'd7;

    // Result of the shared shift unit
    typedef struct packed {
        logic [DATA_W-1:0] low;   // low k bits of the buffer
        logic [BUF_W-1:0]  rest;  // buffer shifted right by k
    } bfp_shift_res_t;

    // Mask of the low k bits, k in 0..8
    function automatic logic [DATA_W-1:0] value_mask(input logic [SHAMT_W-1:0] k);
        logic [DATA_W:0] m;
        m = (9'd1 << k) - 9'd1;
        return m[DATA_W-1:0];
    endfunction

endpackage

### hdl/bfp_shift_unit.sv
// ----------------------------------------------------------------------------
// bfp_shift_unit: shared extract-and-shift unit
// Takes the low k bits of the bit buffer as one result and shifts the
// buffer right by k. Used once per emitted result by the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfp_shift_unit import bfp_pkg::*; (
    input  logic [BUF_W-1:0]   buf_in,
    input  logic [SHAMT_W-1:0] shamt,
    output bfp_shift_res_t     res
);

    // Extract low field and drop it from the buffer
    always_comb begin
        res.low  = buf_in[DATA_W-1:0] & value_mask(shamt);
        res.rest = buf_in >> shamt;
    end

endmodule

### hdl/bit_field_packer_unpacker_top.sv
// ----------------------------------------------------------------------------
// bit_field_packer_unpacker_top: LSB-first bit packer / unpacker
// Pack mode (mode 0): each request on s_ carries one value of value_width
// bits; completed bytes leave on m_, and after value_count values the last
// partial byte is flushed with zero padding. Unpack mode (mode 1): each
// request is one packed byte; up to eight values leave on m_, padding after
// value_count values is dropped. m_run_last marks the last result of a
// request, m_message_end the final result of a message.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data; the user
// must do so only while idle: the block itself does not enforce this.
// Sequencing: a request is taken in the idle state; in the step state the
// sequencer loads each result of the shared shift unit into the output
// register. With no result (pack, byte not yet full) it returns to idle.
// The output register lets the next request be accepted while the last
// result still waits. If the receiver stalls, the sequencer holds until the
// output register frees. Reset (aresetn low, synchronous) clears the held
// bits and the value counter and sets mode 0, width 8, count 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bit_field_packer_unpacker_top import bfp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // Input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [DATA_W-1:0]    s_in_data,
    // Result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DATA_W-1:0]    m_out_data,
    output logic                 m_run_last,
    output logic                 m_message_end
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_STEP = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic                 mode_reg;
    logic [HELD_W-1:0]    width_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [BUF_W-1:0]     buf_reg, buf_next;
    logic [HELD_W-1:0]    bits_held_reg, bits_held_next;
    logic [CNT_W-1:0]     values_done_reg, values_done_next;
    logic                 fin_reg, fin_next;
    logic [EMIT_W-1:0]    emit_cnt_reg, emit_cnt_next;
    logic                 m_valid_reg;
    logic [DATA_W-1:0]    m_data_reg;
    logic                 m_last_reg;
    logic                 m_end_reg;

    logic [HELD_W-1:0]    w_eff;
    logic [CNT_W-1:0]     cnt_eff;
    logic [CNT_W-1:0]     vd_inc;
    logic                 count_hit;
    logic                 accept;
    logic [DATA_W-1:0]    din_masked;
    logic [BUF_W-1:0]     merged_buf;
    logic [HELD_W-1:0]    merged_held;
    logic                 out_free;
    logic                 emit_full;
    logic                 emit_part;
    logic                 emit;
    logic                 e_end;
    logic                 e_last;
    logic                 out_load;
    logic [SHAMT_W-1:0]   shamt;
    logic [HELD_W-1:0]    held_left;
    bfp_shift_res_t       sh_res;

    // Effective settings
    always_comb begin
        if (width_reg == '0) begin
            w_eff = 4'd1;
        end else if (width_reg > BYTE_BITS) begin
            w_eff = BYTE_BITS;
        end else begin
            w_eff = width_reg;
        end
        cnt_eff = (count_reg == '0) ? 32'd1 : count_reg;
    end

    // Shared counter increment and end-of-message compare
    assign vd_inc    = values_done_reg + 32'd1;
    assign count_hit = (vd_inc >= cnt_eff);

    // Append the incoming field above the held bits
    assign accept      = s_valid && s_ready;
    assign din_masked  = (mode_reg == MODE_PACK) ? (s_in_data & value_mask(w_eff)) : s_in_data;
    assign merged_buf  = buf_reg | (BUF_W'(din_masked) << bits_held_reg);
    assign merged_held = bits_held_reg + ((mode_reg == MODE_PACK) ? w_eff : BYTE_BITS);

    // Emission decision for the current step
    always_comb begin
        emit_full = 1'b0;
        emit_part = 1'b0;
        if (mode_reg == MODE_PACK) begin
            emit_full = (bits_held_reg >= BYTE_BITS);
            emit_part = !emit_full && fin_reg && (bits_held_reg != '0);
            emit      = emit_full || emit_part;
            shamt     = emit_full ? BYTE_BITS : bits_held_reg;
            e_end     = emit_full ? (fin_reg && (bits_held_reg == BYTE_BITS)) : 1'b1;
            e_last    = emit_full ? (!fin_reg || (bits_held_reg == BYTE_BITS)) : 1'b1;
        end else begin
            emit      = (bits_held_reg >= w_eff);
            shamt     = w_eff;
            e_end     = count_hit;
            e_last    = count_hit || ((bits_held_reg - w_eff) < w_eff)
                        || (emit_cnt_reg == EMIT_MAX);
        end
    end

    assign held_left = bits_held_reg - shamt;

    bfp_shift_unit u_shift (
        .buf_in (buf_reg),
        .shamt  (shamt),
        .res    (sh_res)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_STEP) && emit && out_free;

    // Sequencer and message state
    always_comb begin
        state_next       = state_reg;
        buf_next         = buf_reg;
        bits_held_next   = bits_held_reg;
        values_done_next = values_done_reg;
        fin_next         = fin_reg;
        emit_cnt_next    = emit_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    buf_next       = merged_buf;
                    bits_held_next = merged_held;
                    emit_cnt_next  = '0;
                    fin_next       = 1'b0;
                    if (mode_reg == MODE_PACK) begin
                        fin_next         = count_hit;
                        values_done_next = count_hit ? '0 : vd_inc;
                    end
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (!emit) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    emit_cnt_next = emit_cnt_reg + 3'd1;
                    if (e_end) begin
                        buf_next         = '0;
                        bits_held_next   = '0;
                        values_done_next = '0;
                    end else begin
                        buf_next       = sh_res.rest;
                        bits_held_next = held_left;
                        if (mode_reg == MODE_UNPACK) begin
                            values_done_next = vd_inc;
                        end
                    end
                    if (e_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            buf_reg         <= '0;
            bits_held_reg   <= '0;
            values_done_reg <= '0;
            fin_reg         <= 1'b0;
            emit_cnt_reg    <= '0;
        end else begin
            state_reg       <= state_next;
            buf_reg         <= buf_next;
            bits_held_reg   <= bits_held_next;
            values_done_reg <= values_done_next;
            fin_reg         <= fin_next;
            emit_cnt_reg    <= emit_cnt_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_PACK;
            width_reg <= RESET_WIDTH;
            count_reg <= RESET_COUNT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_data[0];
                REG_WIDTH: width_reg <= cfg_data[HELD_W-1:0];
                REG_COUNT: count_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= sh_res.low;
            m_last_reg <= e_last;
            m_end_reg  <= e_end;
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_out_data    = m_data_reg;
    assign m_run_last    = m_last_reg;
    assign m_message_end = m_end_reg;

`ifndef SYNTHESIS
    // Fewer than a byte is ever left over between requests
    a_held_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (bits_held_reg < BYTE_BITS))
        else $error("bits held above seven while idle");

    // The final result of a message also closes its request
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_message_end) |-> m_run_last)
        else $error("message end without run last");

    // Ending a message restarts the value counter
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && e_end) |=> (values_done_reg == '0) && (bits_held_reg == '0))
        else $error("message state not cleared at message end");

    // A packed value yields at most two bytes
    a_pack_two: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_STEP) && (mode_reg == MODE_PACK)) |-> (emit_cnt_reg < 3'd2))
        else $error("pack request produced more than two bytes");
`endif

endmodule
